// ----- hdl/flfr_pkg.sv -----
// ---------------------------------------------------------------------------
// Fixed-length frame receiver package
// Shared constants, the controller state type and the chain control group.
// ---------------------------------------------------------------------------
`default_nettype none

package flfr_pkg;

   // Default frame store depth in bytes
   localparam int MAX_FRAME_DEF = 32;

   // Shortest frame: two header bytes, station id, one payload byte, two tail bytes
   localparam int MIN_FRAME = 6;

   // Width of the running byte count and of the frame length register
   localparam int FILL_W = 6;

   // Width of the byte index carried in each result
   localparam int INDEX_W = 5;

   // Frame delimiters
   localparam logic [7:0] HEAD_FIRST  = 8'hAA;
   localparam logic [7:0] HEAD_SECOND = 8'h55;
   localparam logic [7:0] TAIL_FIRST  = 8'hA5;
   localparam logic [7:0] TAIL_SECOND = 8'h5A;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_ID   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 1'b1;

   // Reset values of the registers
   localparam logic [7:0]        STATION_ID_RST   = 8'd1;
   localparam logic [FILL_W-1:0] FRAME_LENGTH_RST = 6'd9;

   // Controller states
   typedef enum logic [1:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   // Shift command for the row of byte cells
   typedef struct packed {
      logic       shift;
      logic [7:0] data;
   } chain_ctrl_type;

endpackage : flfr_pkg

`default_nettype wire

// ----- hdl/flfr_cell.sv -----
// ---------------------------------------------------------------------------
// Frame store cell
// Holds one byte and passes it to the next cell whenever the row shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module flfr_cell (
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire logic [7:0] din,
   output logic [7:0]      dout
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Take the neighbour's byte on a shift, hold otherwise
   always_comb begin
      byte_in = shift ? din : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign dout = byte_ff;

endmodule : flfr_cell

`default_nettype wire

// ----- hdl/flfr_chain.sv -----
// ---------------------------------------------------------------------------
// Frame store chain
// Row of byte cells; new bytes enter at cell zero and move up one cell per
// shift, so the byte at cell len-1 leaves the frame in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module flfr_chain #(
   parameter int MAX_FRAME = flfr_pkg::MAX_FRAME_DEF,
   localparam int IDX_W = $clog2(MAX_FRAME)
) (
   input  wire logic                    clock,
   input  wire flfr_pkg::chain_ctrl_type ctrl,
   input  wire logic [IDX_W-1:0]        tap_sel,
   output logic [7:0]                   tap_data,
   output logic [7:0]                   head_data
);

   logic [7:0] cell_q [MAX_FRAME];

   // Cell zero takes the incoming byte, every other cell its lower neighbour
   for (genvar i = 0; i < MAX_FRAME; i++) begin : g_cell
      if (i == 0) begin : g_first
         flfr_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .din   (ctrl.data),
            .dout  (cell_q[i])
         );
      end else begin : g_next
         flfr_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .din   (cell_q[i-1]),
            .dout  (cell_q[i])
         );
      end
   end

   // Output tap at the end of the current frame length
   assign tap_data  = cell_q[tap_sel];
   assign head_data = cell_q[0];

endmodule : flfr_chain

`default_nettype wire

// ----- hdl/fixed_length_frame_receiver.sv -----
// ---------------------------------------------------------------------------
// Fixed-length frame receiver
// Hunts for 0xAA 0x55 <station id> ... 0xA5 0x5A frames of the configured
// length and emits a good frame as a run of bytes, a bad tail as one error.
// ---------------------------------------------------------------------------
// The first result of a good frame is registered in the drain state that its
// last byte enters; an error result as the bad tail byte is accepted.
// Throughput: one byte per cycle in hunt or collect, one result per cycle in
// drain from the cell row, each while the output is free; input held in drain.
// Reset: synchronous, active high; returns to header hunt with default
// registers. Frame store cells are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_length_frame_receiver #(
   parameter int MAX_FRAME = flfr_pkg::MAX_FRAME_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   // Received bytes
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] rx_byte

   // Frame results
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,   // [7:0] frame_byte,
                                                              // [12:8] byte_index
   output logic                                  rsp_tlast,   // is_last
   output logic                                  rsp_tuser,   // status

   // Configuration writes
   input  wire logic                             csr_we,
   input  wire logic [flfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_wdata
);

   localparam int FILL_W = flfr_pkg::FILL_W;
   localparam int LEN_W  = $clog2(MAX_FRAME + 1);
   localparam int IDX_W  = $clog2(MAX_FRAME);
   localparam int CMP_W  = (LEN_W > FILL_W) ? LEN_W : FILL_W;

   // Configuration registers
   logic [7:0]        station_id_ff;
   logic [FILL_W-1:0] frame_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_id_ff   <= flfr_pkg::STATION_ID_RST;
         frame_length_ff <= flfr_pkg::FRAME_LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            flfr_pkg::CSR_STATION_ID:   station_id_ff   <= csr_wdata;
            flfr_pkg::CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the frame length into the supported range
   logic [CMP_W-1:0] length_ext;
   logic [LEN_W-1:0] frame_len;

   always_comb begin
      length_ext = CMP_W'(frame_length_ff);
      priority if (length_ext < CMP_W'(flfr_pkg::MIN_FRAME)) begin
         frame_len = LEN_W'(flfr_pkg::MIN_FRAME);
      end else if (length_ext > CMP_W'(MAX_FRAME)) begin
         frame_len = LEN_W'(MAX_FRAME);
      end else begin
         frame_len = LEN_W'(length_ext);
      end
   end

   // Controller and output registers
   flfr_pkg::state_type state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [LEN_W-1:0]    drain_ff, drain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [flfr_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_status_ff, rsp_status_in;

   flfr_pkg::chain_ctrl_type chain_ctrl;
   logic [7:0]       tap_data;
   logic [7:0]       head_data;
   logic [IDX_W-1:0] tap_sel;

   logic             rsp_free;
   logic             accept;
   logic [FILL_W-1:0] fill_next;
   logic [CMP_W-1:0] fill_cmp;
   logic [CMP_W-1:0] len_cmp;
   logic [CMP_W-1:0] drain_cmp;

   assign tap_sel = IDX_W'(frame_len - LEN_W'(1));

   flfr_chain #(
      .MAX_FRAME (MAX_FRAME)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .tap_sel   (tap_sel),
      .tap_data  (tap_data),
      .head_data (head_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flfr_pkg::ST_HUNT;
         fill_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      rsp_free   = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff != flfr_pkg::ST_DRAIN) && rsp_free;
      accept     = req_tvalid && req_tready;

      fill_next = FILL_W'(fill_ff + FILL_W'(1));
      fill_cmp  = CMP_W'(fill_next);
      len_cmp   = CMP_W'(frame_len);
      drain_cmp = CMP_W'(drain_ff);

      state_in      = state_ff;
      fill_in       = fill_ff;
      drain_in      = drain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      chain_ctrl.shift = 1'b0;
      chain_ctrl.data  = req_tdata;

      unique case (state_ff)
         // Match header and station id; any mismatch restarts the hunt
         flfr_pkg::ST_HUNT: begin
            if (accept) begin
               priority if (fill_ff == '0) begin
                  if (req_tdata == flfr_pkg::HEAD_FIRST) begin
                     chain_ctrl.shift = 1'b1;
                     fill_in          = fill_next;
                  end
               end else if (fill_ff == FILL_W'(1)) begin
                  chain_ctrl.shift = 1'b1;
                  fill_in = (req_tdata == flfr_pkg::HEAD_SECOND) ? fill_next : '0;
               end else begin
                  chain_ctrl.shift = 1'b1;
                  if (req_tdata == station_id_ff) begin
                     fill_in  = fill_next;
                     state_in = flfr_pkg::ST_COLLECT;
                  end else begin
                     fill_in = '0;
                  end
               end
            end
         end

         // Store bytes until the frame length is reached, then check the tail
         flfr_pkg::ST_COLLECT: begin
            if (accept) begin
               chain_ctrl.shift = 1'b1;
               priority if (fill_cmp > len_cmp || fill_next == '0) begin
                  fill_in  = '0;
                  state_in = flfr_pkg::ST_HUNT;
               end else if (fill_cmp < len_cmp) begin
                  fill_in = fill_next;
               end else begin
                  fill_in = '0;
                  if (req_tdata == flfr_pkg::TAIL_SECOND &&
                      head_data == flfr_pkg::TAIL_FIRST) begin
                     drain_in = '0;
                     state_in = flfr_pkg::ST_DRAIN;
                  end else begin
                     state_in      = flfr_pkg::ST_HUNT;
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = '0;
                     rsp_index_in  = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = 1'b1;
                  end
               end
            end
         end

         // Advance the row one cell per result, oldest byte at the tap
         flfr_pkg::ST_DRAIN: begin
            if (rsp_free) begin
               chain_ctrl.shift = 1'b1;
               chain_ctrl.data  = '0;
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = tap_data;
               rsp_index_in     = drain_cmp[flfr_pkg::INDEX_W-1:0];
               rsp_status_in    = 1'b0;
               rsp_last_in      = (LEN_W'(drain_ff + LEN_W'(1)) == frame_len);
               drain_in         = LEN_W'(drain_ff + LEN_W'(1));
               if (rsp_last_in) begin
                  state_in = flfr_pkg::ST_HUNT;
               end
            end
         end

         default: begin
            state_in = flfr_pkg::ST_HUNT;
            fill_in  = '0;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_index_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule : fixed_length_frame_receiver

`default_nettype wire
